// ===== design/ggm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ggm_pkg;

  localparam int unsigned TagBitsDef = 256;

  typedef struct packed {
    logic [8:0]  start_level;
    logic [63:0] tag_word3;
    logic [63:0] tag_word2;
    logic [63:0] tag_word1;
    logic [63:0] tag_word0;
    logic [63:0] key_high;
    logic [63:0] key_low;
  } ggm_in_t;

  typedef struct packed {
    logic [63:0] prf_high;
    logic [63:0] prf_low;
  } ggm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } ggm_state_e;

  typedef struct packed {
    logic load;
    logic blk_start;
    logic round;
  } ggm_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic last_round;
  } ggm_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ===== design/ggm_tree_prf_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// GGM tree PRF: walks from start_level to TagBits, one AES-128 encryption
// per level, key schedule computed on the fly. Each level is one load step
// plus ten rounds of the single round unit; one item at a time.
module ggm_tree_prf_eval import ggm_pkg::*; #(
  parameter int unsigned TagBits = TagBitsDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  var  ggm_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output ggm_out_t     out_data_o
);

  ggm_cmd_t cmd;
  ggm_sts_t sts;

  ggm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ggm_dp #(.TagBits(TagBits)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .sts_o(sts), .out_data_o
  );

endmodule
`default_nettype wire

// ===== design/ggm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ggm_ctrl import ggm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  var  ggm_sts_t sts_i,
  output ggm_cmd_t      cmd_o
);

  ggm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = sts_i.walk_done ? ST_DONE : ST_ROUND;
      ST_ROUND: begin
        if (sts_i.last_round) state_d = ST_LOAD;
      end
      ST_DONE: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_DONE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.blk_start = (state_q == ST_LOAD) && !sts_i.walk_done;
    cmd_o.round     = (state_q == ST_ROUND);
  end

endmodule
`default_nettype wire

// ===== design/ggm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ggm_dp import ggm_pkg::*; #(
  parameter int unsigned TagBits = TagBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  var  ggm_in_t  in_data_i,
  input  var  ggm_cmd_t cmd_i,
  output ggm_sts_t      sts_o,
  output ggm_out_t      out_data_o
);

  localparam int unsigned LW = $clog2(TagBits + 1);

  logic [255:0]   tag_q;
  logic [LW-1:0]  lvl_q;
  logic [127:0]   key_q, rk_q, st_q;
  logic [3:0]     rnd_q;
  logic [7:0]     rcon_q;

  logic [255:0] tag_all;
  logic [7:0]   bidx;
  logic         bit_sel;
  logic [127:0] blk, nrk, sb, sr, mc, nst;
  logic [31:0]  w3, tw;

  assign tag_all = {in_data_i.tag_word3, in_data_i.tag_word2,
                    in_data_i.tag_word1, in_data_i.tag_word0};
  assign bidx    = 8'(TagBits - 1 - int'(lvl_q));
  assign bit_sel = tag_q[bidx];

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk[8*j +: 8] = {7'd0, 1'(j % 2) ^ bit_sel};
    end
  end

  // key schedule, one round key a cycle while in the round state
  assign w3 = rk_q[127:96];
  assign tw = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]),
               sbox(w3[15:8]) ^ rcon_q};
  always_comb begin
    nrk[31:0]   = rk_q[31:0] ^ tw;
    nrk[63:32]  = rk_q[63:32] ^ nrk[31:0];
    nrk[95:64]  = rk_q[95:64] ^ nrk[63:32];
    nrk[127:96] = rk_q[127:96] ^ nrk[95:64];
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, t;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sr[32*c + 8*j +: 8] = sbox(st_q[32*((c + j) % 4) + 8*j +: 8]);
      end
    end
    sb = sr;
    for (int c = 0; c < 4; c++) begin
      a0 = sb[32*c +: 8];
      a1 = sb[32*c + 8 +: 8];
      a2 = sb[32*c + 16 +: 8];
      a3 = sb[32*c + 24 +: 8];
      t  = a0 ^ a1 ^ a2 ^ a3;
      mc[32*c +: 8]      = a0 ^ t ^ gf_dbl(a0 ^ a1);
      mc[32*c + 8 +: 8]  = a1 ^ t ^ gf_dbl(a1 ^ a2);
      mc[32*c + 16 +: 8] = a2 ^ t ^ gf_dbl(a2 ^ a3);
      mc[32*c + 24 +: 8] = a3 ^ t ^ gf_dbl(a3 ^ a0);
    end
    nst = ((rnd_q == 4'd10) ? sb : mc) ^ nrk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (cmd_i.blk_start) begin
      rnd_q <= 4'd1;
    end else if (cmd_i.round) begin
      rnd_q <= rnd_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= {in_data_i.key_high, in_data_i.key_low};
      tag_q <= tag_all;
      lvl_q <= (in_data_i.start_level >= 9'(TagBits)) ? LW'(TagBits)
                                                      : LW'(in_data_i.start_level);
    end else if (cmd_i.blk_start) begin
      rk_q   <= key_q;
      st_q   <= blk ^ key_q;
      rcon_q <= 8'h01;
    end else if (cmd_i.round) begin
      rk_q   <= nrk;
      st_q   <= nst;
      rcon_q <= gf_dbl(rcon_q);
      if (rnd_q == 4'd10) begin
        key_q <= nst;
        lvl_q <= lvl_q + LW'(1);
      end
    end
  end

  assign sts_o.walk_done  = (lvl_q == LW'(TagBits));
  assign sts_o.last_round = (rnd_q == 4'd10);
  assign out_data_o.prf_low  = key_q[63:0];
  assign out_data_o.prf_high = key_q[127:64];

endmodule
`default_nettype wire
